// ----- sv/ipm_homography_remap_unit_macros.svh -----
// Assertion macros shared by the homography remap unit
`ifndef IPM_HOMOGRAPHY_REMAP_UNIT_MACROS_SVH
`define IPM_HOMOGRAPHY_REMAP_UNIT_MACROS_SVH
// assert an implication on the next edge, disabled in reset
`define IPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipm assertion failed");
// assert a same-cycle implication, disabled in reset
`define IPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipm assertion failed");
`endif

// ----- sv/ipm_pkg.sv -----
// Package of types and constants for the homography remap unit
package ipm_pkg;
    localparam int OUT_WIDTH  = 1024;
    localparam int OUT_HEIGHT = 1024;
    localparam int SRC_WIDTH  = 2048;
    localparam int SRC_HEIGHT = 2048;
    localparam int NUM_REGS   = 8;
    localparam int COEF_W     = 32;
    localparam int ACC_W      = 46;
    // quotient bits resolved by the divider chain (covers 2^44/2^0 range)
    localparam int Q_W        = 46;
    localparam int RES_W      = 11;

    localparam logic [2:0] REG_X_COL   = 3'd0;
    localparam logic [2:0] REG_X_ROW   = 3'd1;
    localparam logic [2:0] REG_X_CONST = 3'd2;
    localparam logic [2:0] REG_Y_COL   = 3'd3;
    localparam logic [2:0] REG_Y_ROW   = 3'd4;
    localparam logic [2:0] REG_Y_CONST = 3'd5;
    localparam logic [2:0] REG_W_COL   = 3'd6;
    localparam logic [2:0] REG_W_ROW   = 3'd7;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
    } t_in_item;

    typedef struct packed {
        logic [RES_W-1:0] src_x;
        logic [RES_W-1:0] src_y;
        logic             inside_res;
    } t_out_item;

    // data handed from cell to cell in the divider chain
    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [Q_W:0]     rem_x;   // partial remainder
        logic [Q_W:0]     rem_y;
        logic [Q_W-1:0]   num_x;   // dividend bits still to shift in
        logic [Q_W-1:0]   num_y;
        logic [Q_W-1:0]   den2;    // 2*den
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } t_div_lane;
endpackage

// ----- sv/ipm_homography_remap_unit.sv -----
// Homography remap unit: config registers, product front end, divider chain
// Pipeline: two front-end stages, 46 divider cells and one output register.
// Throughput: one item per cycle; each divider cell resolves one quotient bit.
// Reset (synchronous, active low) loads the identity map and empties the chain.
// The receiver cannot stall; busy is always low.
`include "ipm_homography_remap_unit_macros.svh"
module ipm_homography_remap_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ipm_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output ipm_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int N = ipm_pkg::Q_W;
    logic signed [ipm_pkg::COEF_W-1:0] r_coef [ipm_pkg::NUM_REGS];
    ipm_pkg::t_div_lane lane [N+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[ipm_pkg::REG_X_COL]   <= 32'sd1048576;
            r_coef[ipm_pkg::REG_X_ROW]   <= '0;
            r_coef[ipm_pkg::REG_X_CONST] <= '0;
            r_coef[ipm_pkg::REG_Y_COL]   <= '0;
            r_coef[ipm_pkg::REG_Y_ROW]   <= 32'sd1048576;
            r_coef[ipm_pkg::REG_Y_CONST] <= '0;
            r_coef[ipm_pkg::REG_W_COL]   <= '0;
            r_coef[ipm_pkg::REG_W_ROW]   <= '0;
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    ipm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start), .i_item(i_item),
        .i_coef(r_coef), .o_lane(lane[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        ipm_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lane(lane[g]), .o_lane(lane[g+1])
        );
    end

    // limit checks and output register
    logic ok_fin;
    assign ok_fin = lane[N].ok
        && (lane[N].q_x < N'(ipm_pkg::SRC_WIDTH))
        && (lane[N].q_y < N'(ipm_pkg::SRC_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= lane[N].vld;
        end
        o_item.inside_res <= ok_fin;
        o_item.src_x <= ok_fin ? lane[N].q_x[ipm_pkg::RES_W-1:0] : '0;
        o_item.src_y <= ok_fin ? lane[N].q_y[ipm_pkg::RES_W-1:0] : '0;
    end

    `IPM_ASSERT_NEXT(a_front_vld, i_clk, i_rst_n, start, u_front.r_vld1)
    `IPM_ASSERT_NOW(a_zero_out, i_clk, i_rst_n, o_strobe && !o_item.inside_res,
                    o_item.src_x == '0 && o_item.src_y == '0)
    `IPM_ASSERT_NEXT(a_strobe, i_clk, i_rst_n, lane[N].vld, o_strobe)
endmodule

// ----- sv/ipm_front.sv -----
// Front end: coefficient products and sums, two pipeline stages
module ipm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  ipm_pkg::t_in_item          i_item,
    input  logic signed [ipm_pkg::COEF_W-1:0] i_coef [ipm_pkg::NUM_REGS],
    output ipm_pkg::t_div_lane         o_lane
);
    localparam int P_W = ipm_pkg::COEF_W + 11;
    logic               r_vld1;
    logic               r_inrange1;
    logic signed [P_W-1:0] r_p [6];
    logic signed [ipm_pkg::COEF_W-1:0] r_kx, r_ky;
    logic signed [11:0] col_s, row_s;

    assign col_s = {2'b00, i_item.out_col};
    assign row_s = {2'b00, i_item.out_row};

    // stage 1: six products, one register after each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_inrange1 <= ({22'd0, i_item.out_col} < ipm_pkg::OUT_WIDTH)
                   && ({22'd0, i_item.out_row} < ipm_pkg::OUT_HEIGHT);
        r_p[0] <= P_W'(i_coef[ipm_pkg::REG_X_COL] * col_s);
        r_p[1] <= P_W'(i_coef[ipm_pkg::REG_X_ROW] * row_s);
        r_p[2] <= P_W'(i_coef[ipm_pkg::REG_Y_COL] * col_s);
        r_p[3] <= P_W'(i_coef[ipm_pkg::REG_Y_ROW] * row_s);
        r_p[4] <= P_W'(i_coef[ipm_pkg::REG_W_COL] * col_s);
        r_p[5] <= P_W'(i_coef[ipm_pkg::REG_W_ROW] * row_s);
        r_kx   <= i_coef[ipm_pkg::REG_X_CONST];
        r_ky   <= i_coef[ipm_pkg::REG_Y_CONST];
    end

    // stage 2: sums, rounding offset and sign checks
    logic signed [ipm_pkg::ACC_W-1:0] nx, ny, den, n2x, n2y;
    always_comb begin
        nx  = ipm_pkg::ACC_W'(r_p[0]) + ipm_pkg::ACC_W'(r_p[1]) + ipm_pkg::ACC_W'(r_kx);
        ny  = ipm_pkg::ACC_W'(r_p[2]) + ipm_pkg::ACC_W'(r_p[3]) + ipm_pkg::ACC_W'(r_ky);
        den = ipm_pkg::ACC_W'(r_p[4]) + ipm_pkg::ACC_W'(r_p[5])
            + ipm_pkg::ACC_W'(64'sd1048576);
        n2x = (nx <<< 1) + den;
        n2y = (ny <<< 1) + den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_lane.vld <= 1'b0;
        end else begin
            o_lane.vld <= r_vld1;
        end
        o_lane.ok    <= r_inrange1 && (den > 0) && !n2x[ipm_pkg::ACC_W-1]
                     && !n2y[ipm_pkg::ACC_W-1];
        o_lane.rem_x <= '0;
        o_lane.rem_y <= '0;
        o_lane.num_x <= n2x;
        o_lane.num_y <= n2y;
        o_lane.den2  <= den <<< 1;
        o_lane.q_x   <= '0;
        o_lane.q_y   <= '0;
    end
endmodule

// ----- sv/ipm_div_cell.sv -----
// One restoring division cell: resolves one quotient bit of x and y
module ipm_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipm_pkg::t_div_lane i_lane,
    output ipm_pkg::t_div_lane o_lane
);
    localparam int W = ipm_pkg::Q_W;
    logic [W:0] tx, ty, dx, dy;
    ipm_pkg::t_div_lane n_lane;

    always_comb begin
        n_lane = i_lane;
        tx = {i_lane.rem_x[W-1:0], i_lane.num_x[W-1]};
        ty = {i_lane.rem_y[W-1:0], i_lane.num_y[W-1]};
        dx = tx - {1'b0, i_lane.den2};
        dy = ty - {1'b0, i_lane.den2};
        n_lane.rem_x = dx[W] ? tx : dx;
        n_lane.rem_y = dy[W] ? ty : dy;
        n_lane.num_x = {i_lane.num_x[W-2:0], 1'b0};
        n_lane.num_y = {i_lane.num_y[W-2:0], 1'b0};
        n_lane.q_x   = {i_lane.q_x[W-2:0], ~dx[W]};
        n_lane.q_y   = {i_lane.q_y[W-2:0], ~dy[W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_lane.vld <= 1'b0;
            o_lane[$bits(o_lane)-2:0] <= n_lane[$bits(n_lane)-2:0];
        end else begin
            o_lane <= n_lane;
        end
    end
endmodule
